// File: hw/rtl/fspa_pkg.sv
// Package for the fixed-slot pool allocator.
// Holds sizes, operation and status codes, register map and shared types.
// No dependencies.
package fspa_pkg;

    localparam int MAX_SLOTS         = 1024;
    localparam int IDX_W             = $clog2(MAX_SLOTS);
    localparam int TOP_W             = $clog2(MAX_SLOTS + 1);
    localparam int LOW_WATER_SLOTS   = 3;
    localparam int STACK_ENTRY_LOG2  = 3;   // 8 bytes per stack entry

    localparam int OP_W       = 2;
    localparam int REQ_W      = 32;
    localparam int ADDR_W     = 64;
    localparam int STATUS_W   = 3;
    localparam int LG_W       = 5;
    localparam int CNT_W      = 11;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;

    // Reserved-count sum: slot size (REQ_W + 1 bits) plus the scaled count
    localparam int SUM_W      = REQ_W + 2;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOM         = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_POOL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW   = 3'd4;

    // Register indexes, 8-byte stride
    localparam logic [1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [1:0] REG_SLOT_LOG2  = 2'd1;
    localparam logic [1:0] REG_SLOT_COUNT = 2'd2;

    localparam logic [LG_W-1:0]  RST_SLOT_LOG2  = 5'd12;
    localparam logic [CNT_W-1:0] RST_SLOT_COUNT = 11'd1023;

    typedef struct packed {
        logic [ADDR_W-1:0] pool_base;
        logic [LG_W-1:0]   slot_size_log2;
        logic [CNT_W-1:0]  slot_count;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // Free slots left for a given top; none once top has passed the count.
    function automatic logic [TOP_W-1:0] free_slots(input logic [TOP_W-1:0] top,
                                                   input logic [TOP_W-1:0] count);
        free_slots = (top >= count) ? '0 : count - top;
    endfunction

endpackage

// File: hw/rtl/fspa_in_if.sv
// Request channel of the pool allocator: valid/ready plus request payload.
// Depends on fspa_pkg.
interface fspa_in_if import fspa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output op, output request_bytes, output address,
                    input ready);
    modport sink   (input valid, input op, input request_bytes, input address,
                    output ready);
endinterface

// File: hw/rtl/fspa_out_if.sv
// Response channel of the pool allocator: valid/ready plus result payload.
// Depends on fspa_pkg.
interface fspa_out_if import fspa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   slot_address;
    logic                low_water;

    modport source (output valid, output status, output slot_address, output low_water,
                    input ready);
    modport sink   (input valid, input status, input slot_address, input low_water,
                    output ready);
endinterface

// File: hw/rtl/fspa_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No package dependency.
module fspa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/fspa_cfg.sv
// APB-style register file: pool base, slot size log2, slot count.
// Depends on fspa_pkg.
module fspa_cfg import fspa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);
    logic [ADDR_W-1:0] r_pool_base;
    logic [LG_W-1:0]   r_slot_log2;
    logic [CNT_W-1:0]  r_slot_count;
    logic [1:0]        reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= '0;
            r_slot_log2  <= RST_SLOT_LOG2;
            r_slot_count <= RST_SLOT_COUNT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_POOL_BASE:  r_pool_base  <= pwdata;
                REG_SLOT_LOG2:  r_slot_log2  <= pwdata[LG_W-1:0];
                REG_SLOT_COUNT: r_slot_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POOL_BASE:  prdata = r_pool_base;
            REG_SLOT_LOG2:  prdata = APB_DATA_W'(r_slot_log2);
            REG_SLOT_COUNT: prdata = APB_DATA_W'(r_slot_count);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = '{pool_base: r_pool_base, slot_size_log2: r_slot_log2,
                     slot_count: r_slot_count};
endmodule

// File: hw/rtl/fspa_ctrl.sv
// Sequencer of the pool allocator: read-modify-write of the free stack,
// top pointer, low-water flag and response register. Depends on fspa_pkg
// and the channel interfaces; drives the stack RAM through t_mem_req.
module fspa_ctrl import fspa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    fspa_in_if.sink           i_in,
    fspa_out_if.source        o_out,
    output t_mem_req          o_mem,
    input  logic [IDX_W-1:0]  i_rdata
);
    typedef enum logic [1:0] {S_IDLE, S_PREP, S_EXEC, S_INIT} t_state;

    t_state              r_state, n_state;
    logic [TOP_W-1:0]    r_top, n_top;
    logic                r_flag, n_flag;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]   r_slot_addr, n_slot_addr;
    logic                r_low_water, n_low_water;

    // item payload and derived operands
    logic [OP_W-1:0]     r_op;
    logic [REQ_W-1:0]    r_req;
    logic [ADDR_W-1:0]   r_addr;
    logic [TOP_W-1:0]    r_count, n_count;
    logic [TOP_W-1:0]    r_res, n_res;
    logic                r_too_big, n_too_big;
    logic [ADDR_W-1:0]   r_off, n_off;
    logic                r_below, n_below;
    logic [TOP_W-1:0]    r_idx, n_idx;

    logic [LG_W-1:0]     lg;
    logic [REQ_W:0]      size;
    logic [TOP_W-1:0]    count_c;
    logic [SUM_W-1:0]    res_sum;
    logic [SUM_W-1:0]    res_sh;
    logic [TOP_W-1:0]    res_c;
    logic [TOP_W-1:0]    idx_p1;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [ADDR_W-1:0]   slot;
    logic                in_pool;
    logic [TOP_W-1:0]    top_inc, top_dec;
    logic                can_emit;
    logic                accept;
    t_mem_req            mem;

    assign lg       = i_cfg.slot_size_log2;
    assign size     = (REQ_W+1)'(1) << lg;
    assign count_c  = (32'(i_cfg.slot_count) > MAX_SLOTS) ? TOP_W'(MAX_SLOTS)
                                                          : TOP_W'(i_cfg.slot_count);
    // reserved = ceil(count * entry bytes / slot size), no more than count
    assign res_sum  = (SUM_W'(count_c) << STACK_ENTRY_LOG2) + SUM_W'(size) - SUM_W'(1);
    assign res_sh   = res_sum >> lg;
    assign res_c    = (res_sh > SUM_W'(count_c)) ? count_c : TOP_W'(res_sh);

    assign idx_p1     = TOP_W'(i_rdata) + TOP_W'(1);
    assign alloc_addr = i_cfg.pool_base + (ADDR_W'(idx_p1) << lg);
    assign slot       = r_off >> lg;
    assign in_pool    = !r_below && (slot != '0) && (slot <= ADDR_W'(r_count));
    assign top_inc    = r_top + TOP_W'(1);
    assign top_dec    = r_top - TOP_W'(1);

    assign can_emit   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_flag      = r_flag;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_slot_addr = r_slot_addr;
        n_low_water = r_low_water;
        n_count     = r_count;
        n_res       = r_res;
        n_too_big   = r_too_big;
        n_off       = r_off;
        n_below     = r_below;
        n_idx       = r_idx;
        mem         = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_count             = count_c;
                n_res               = res_c;
                n_idx               = res_c;
                n_too_big           = {1'b0, r_req} > size;
                {n_below, n_off}    = {1'b0, r_addr} - {1'b0, i_cfg.pool_base};
                // fetch the entry on top for an allocation
                mem.re              = 1'b1;
                mem.raddr           = r_top[IDX_W-1:0];
                n_state             = (r_op == OP_INIT) ? S_INIT : S_EXEC;
            end
            S_INIT: begin
                if (r_idx < r_count) begin
                    mem.we    = 1'b1;
                    mem.waddr = r_idx[IDX_W-1:0];
                    mem.wdata = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + TOP_W'(1);
                end else if (can_emit) begin
                    n_top       = r_res;
                    n_flag      = 1'b0;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_slot_addr = '0;
                    n_low_water = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_EXEC: begin
                if (can_emit) begin
                    n_status    = ST_OK;
                    n_slot_addr = '0;
                    case (r_op)
                        OP_ALLOC: begin
                            if (r_too_big) begin
                                n_status = ST_TOO_BIG;
                            end else if (r_top >= r_count) begin
                                n_status = ST_OOM;
                            end else begin
                                n_top       = top_inc;
                                n_slot_addr = alloc_addr;
                                if (free_slots(top_inc, r_count) < TOP_W'(LOW_WATER_SLOTS)) begin
                                    n_flag = 1'b1;
                                end
                            end
                        end
                        OP_FREE: begin
                            if (!in_pool) begin
                                n_status = ST_NOT_IN_POOL;
                            end else if (r_top <= r_res) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_top     = top_dec;
                                mem.we    = 1'b1;
                                mem.waddr = top_dec[IDX_W-1:0];
                                mem.wdata = IDX_W'(slot - ADDR_W'(1));
                                if (free_slots(top_dec, r_count) >= TOP_W'(LOW_WATER_SLOTS)) begin
                                    n_flag = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                    n_low_water = n_flag;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            r_slot_addr <= '0;
            r_low_water <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_flag      <= n_flag;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_slot_addr <= n_slot_addr;
            r_low_water <= n_low_water;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_in.op;
            r_req  <= i_in.request_bytes;
            r_addr <= i_in.address;
        end
        r_count   <= n_count;
        r_res     <= n_res;
        r_too_big <= n_too_big;
        r_off     <= n_off;
        r_below   <= n_below;
        r_idx     <= n_idx;
    end

    assign o_mem              = mem;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.slot_address = r_slot_addr;
    assign o_out.low_water    = r_low_water;

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(MAX_SLOTS))
        else $error("free stack top beyond stack depth");

    a_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem.we |-> (r_state == S_INIT || r_state == S_EXEC))
        else $error("stack written outside init sweep or execute");

    a_resp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_INIT || $past(r_state) == S_EXEC))
        else $error("response raised without a finishing step");

    a_addr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_slot_addr != '0) |-> r_status == ST_OK)
        else $error("slot address given with a failing status");

    a_top_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT && r_state != S_EXEC) |=> $stable(r_top))
        else $error("top moved outside a finishing step");
endmodule

// File: hw/rtl/fixed_slot_pool_allocator_unit.sv
// Fixed-slot pool allocator: free-index stack in a 1024-entry sync RAM.
// Alloc, free and no-op: prepare then execute, which registers the result.
// Init: after prepare, one stack entry written per cycle from the reserved count up to the slot count.
// One at a time: the next transaction is accepted only back in idle, which a waiting response delays.
// Synchronous active-low reset clears top, flag and handshakes; stack
// contents are undefined until the first init.
module fixed_slot_pool_allocator_unit import fspa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fspa_in_if.sink               i_in,
    fspa_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    t_cfg             cfg;
    t_mem_req         mem;
    logic [IDX_W-1:0] rdata;

    fspa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fspa_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (IDX_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    fspa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_mem   (mem),
        .i_rdata (rdata)
    );
endmodule
